>>> sv/hcsp_pkg.sv
// Shared types and constants for the host command stream parser.
// Depends on nothing; every other file imports it.
package hcsp_pkg;

  localparam int NAME_BYTES   = 64;
  localparam int ADDRESS_BITS = 32;

  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam logic [7:0]  NAME_KEEP = 8'(NAME_BYTES - 1);

  // parse phases
  localparam logic [2:0] PH_CMD       = 3'd0;
  localparam logic [2:0] PH_LOAD_HDR  = 3'd1;
  localparam logic [2:0] PH_LOAD_DATA = 3'd2;
  localparam logic [2:0] PH_JUMP_HDR  = 3'd3;
  localparam logic [2:0] PH_NAME_LEN  = 3'd4;
  localparam logic [2:0] PH_NAME_DATA = 3'd5;

  // command bytes
  localparam logic [7:0] OP_LOAD     = 8'd1;
  localparam logic [7:0] OP_JUMP     = 8'd2;
  localparam logic [7:0] OP_RESET    = 8'd3;
  localparam logic [7:0] OP_REBOOT   = 8'd9;
  localparam logic [7:0] OP_SET_NAME = 8'd10;
  localparam logic [7:0] OP_AR_BEGIN = 8'd11;
  localparam logic [7:0] OP_AR_END   = 8'd12;
  localparam logic [7:0] OP_AR_CLEAR = 8'd13;

  // result events
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_MEM_WRITE = 4'd1;
  localparam logic [3:0] EV_SET_MAIN  = 4'd2;
  localparam logic [3:0] EV_RESET     = 4'd3;
  localparam logic [3:0] EV_NAME_CHAR = 4'd4;
  localparam logic [3:0] EV_NAME_DONE = 4'd5;
  localparam logic [3:0] EV_AR_BEGIN  = 4'd6;
  localparam logic [3:0] EV_AR_END    = 4'd7;
  localparam logic [3:0] EV_AR_CLEAR  = 4'd8;
  localparam logic [3:0] EV_REBOOT    = 4'd9;
  localparam logic [3:0] EV_STOP      = 4'd10;
  localparam logic [3:0] EV_TRUNC     = 4'd11;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_t;

  typedef struct packed {
    logic [3:0]         event_res;
    logic [31:0]        target_address;
    logic [7:0]         data_value;
    logic signed [31:0] program_id;
    logic [5:0]         name_position;
    logic               record_byte;
  } out_t;

endpackage

>>> sv/hcsp_parse.sv
// Frame parser: phase and header registers plus the per-byte next-state logic.
// Depends on hcsp_pkg.
module hcsp_parse import hcsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  in_t  in_item,
  output out_t result
);

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] jump_id_r, jump_id_nxt;
  logic [7:0]  name_total_r, name_total_nxt;
  logic        capture_r, capture_nxt;
  logic        stopped_r, stopped_nxt;

  logic        complete;
  logic [7:0]  b;
  logic [7:0]  kept;
  logic [31:0] offset_inc;
  logic [31:0] idx;

  assign b          = in_item.rx_byte;
  assign offset_inc = offset_r + 32'd1;
  assign idx        = offset_r;
  assign kept       = (name_total_r > NAME_KEEP) ? NAME_KEEP : name_total_r;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    base_nxt       = base_r;
    size_nxt       = size_r;
    offset_nxt     = offset_r;
    jump_id_nxt    = jump_id_r;
    name_total_nxt = name_total_r;
    capture_nxt    = capture_r;
    stopped_nxt    = stopped_r;
    complete       = 1'b1;
    result         = '0;

    if (!stopped_r) begin
      case (phase_r)
        PH_CMD: begin
          case (b)
            OP_LOAD: begin
              phase_nxt          = PH_LOAD_HDR;
              hdr_cnt_nxt        = '0;
              base_nxt           = '0;
              size_nxt           = '0;
              offset_nxt         = '0;
              result.record_byte = capture_r;
              complete           = 1'b0;
            end
            OP_JUMP: begin
              phase_nxt          = PH_JUMP_HDR;
              hdr_cnt_nxt        = '0;
              jump_id_nxt        = '0;
              base_nxt           = '0;
              result.record_byte = capture_r;
              complete           = 1'b0;
            end
            OP_RESET: begin
              result.event_res = EV_RESET;
              capture_nxt      = 1'b0;
            end
            OP_REBOOT: begin
              result.event_res = EV_REBOOT;
              stopped_nxt      = 1'b1;
            end
            OP_SET_NAME: begin
              phase_nxt = PH_NAME_LEN;
              complete  = 1'b0;
            end
            OP_AR_BEGIN: begin
              result.event_res = EV_AR_BEGIN;
              capture_nxt      = 1'b1;
            end
            OP_AR_END: begin
              result.event_res = EV_AR_END;
              capture_nxt      = 1'b0;
            end
            OP_AR_CLEAR: begin
              result.event_res = EV_AR_CLEAR;
              capture_nxt      = 1'b0;
            end
            default: begin
              result.event_res = EV_STOP;
              stopped_nxt      = 1'b1;
            end
          endcase
        end
        PH_LOAD_HDR: begin
          result.record_byte = capture_r;
          if (!hdr_cnt_r[2]) begin
            base_nxt[8*hdr_cnt_r[1:0] +: 8] = b;
          end else begin
            size_nxt[8*hdr_cnt_r[1:0] +: 8] = b;
          end
          if (hdr_cnt_r == 3'd7) begin
            hdr_cnt_nxt = '0;
            offset_nxt  = '0;
            if (size_nxt == 32'd0) begin
              phase_nxt = PH_CMD;
            end else begin
              phase_nxt = PH_LOAD_DATA;
              complete  = 1'b0;
            end
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 3'd1;
            complete    = 1'b0;
          end
        end
        PH_LOAD_DATA: begin
          result.record_byte    = capture_r;
          result.event_res      = EV_MEM_WRITE;
          result.target_address = (base_r + offset_r) & ADDR_MASK;
          result.data_value     = b;
          offset_nxt            = offset_inc;
          if (offset_inc >= size_r) begin
            phase_nxt = PH_CMD;
          end else begin
            complete = 1'b0;
          end
        end
        PH_JUMP_HDR: begin
          result.record_byte = capture_r;
          if (!hdr_cnt_r[2]) begin
            jump_id_nxt[8*hdr_cnt_r[1:0] +: 8] = b;
          end else begin
            base_nxt[8*hdr_cnt_r[1:0] +: 8] = b;
          end
          if (hdr_cnt_r == 3'd7) begin
            hdr_cnt_nxt           = '0;
            result.event_res      = EV_SET_MAIN;
            result.target_address = base_nxt & ADDR_MASK;
            result.program_id     = jump_id_nxt;
            phase_nxt             = PH_CMD;
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 3'd1;
            complete    = 1'b0;
          end
        end
        PH_NAME_LEN: begin
          name_total_nxt = b;
          offset_nxt     = '0;
          if (b == 8'd0) begin
            result.event_res = EV_NAME_DONE;
            phase_nxt        = PH_CMD;
          end else begin
            phase_nxt = PH_NAME_DATA;
            complete  = 1'b0;
          end
        end
        PH_NAME_DATA: begin
          offset_nxt = offset_inc;
          if (offset_inc >= {24'd0, name_total_r}) begin
            result.event_res     = EV_NAME_DONE;
            result.name_position = kept[5:0];
            result.data_value    = (idx < {24'd0, kept}) ? b : 8'd0;
            phase_nxt            = PH_CMD;
          end else begin
            if (idx < {24'd0, kept}) begin
              result.event_res     = EV_NAME_CHAR;
              result.name_position = idx[5:0];
              result.data_value    = b;
            end
            complete = 1'b0;
          end
        end
        default: begin
          phase_nxt = PH_CMD;
        end
      endcase
    end

    if (in_item.buffer_end) begin
      if (!complete) begin
        result.event_res      = EV_TRUNC;
        result.target_address = '0;
        result.data_value     = '0;
        result.program_id     = '0;
        result.name_position  = '0;
      end
      phase_nxt   = PH_CMD;
      hdr_cnt_nxt = '0;
      stopped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_CMD;
      hdr_cnt_r    <= '0;
      base_r       <= '0;
      size_r       <= '0;
      offset_r     <= '0;
      jump_id_r    <= '0;
      name_total_r <= '0;
      capture_r    <= 1'b0;
      stopped_r    <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      base_r       <= base_nxt;
      size_r       <= size_nxt;
      offset_r     <= offset_nxt;
      jump_id_r    <= jump_id_nxt;
      name_total_r <= name_total_nxt;
      capture_r    <= capture_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

endmodule

>>> sv/hcsp_out_reg.sv
// Result register for the parser: holds one result until the consumer takes it.
// Depends on hcsp_pkg.
module hcsp_out_reg import hcsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  out_t load_data,
  output logic free,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic valid_r, valid_nxt;
  out_t data_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

>>> sv/host_command_stream_parser.sv
// Host command stream parser: one received byte in, one event out per byte; the result
// is valid in the cycle after the input transfer. A byte is taken in every cycle
// in which the result register is empty or its result is being taken, so the
// sustained rate is one byte per cycle, set by the single result register.
// Depends on hcsp_pkg, hcsp_parse and hcsp_out_reg.
module host_command_stream_parser import hcsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic step;
  logic free;
  out_t result;

  assign in_ready = free;
  assign step     = in_valid && free;

  hcsp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_item (in_data),
    .result  (result)
  );

  hcsp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .load_data (result),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/hcsp_checker.sv
// Port-level checks for host_command_stream_parser, bound to the top level.
// Depends on hcsp_pkg.
module hcsp_checker import hcsp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("transfer gave no result");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.event_res <= EV_TRUNC)
    else $error("event code out of range");

  a_trunc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == EV_TRUNC |->
      out_data.target_address == '0 && out_data.data_value == '0 &&
      out_data.program_id == '0 && out_data.name_position == '0)
    else $error("truncated result carries payload");

endmodule

bind host_command_stream_parser hcsp_checker u_hcsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> sim/tb_top.sv
// Self-checking testbench for host_command_stream_parser: directed and random command buffers,
// each result checked against a cycle-free model of the frame parser.
// Depends on hcsp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
  import hcsp_pkg::*;

  localparam logic [7:0] OP_STOP     = 8'd14;
  localparam int         CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  host_command_stream_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // parser state as seen from outside
  logic [2:0]  phase;
  logic [2:0]  hdr_cnt;
  logic [31:0] base_addr;
  logic [31:0] pay_size;
  logic [31:0] pay_off;
  logic [31:0] jmp_id;
  logic [7:0]  name_size;
  bit          capturing;
  bit          halted;

  out_t       event_q[$];
  logic [7:0] buf_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int n_checked      = 0;
  int n_bytes        = 0;
  int n_parsed       = 0;
  int n_buffers      = 0;
  int n_long_names   = 0;
  int cycle_count    = 0;
  int ev_seen[16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_parser_state();
    phase     = PH_CMD;
    hdr_cnt   = '0;
    base_addr = '0;
    pay_size  = '0;
    pay_off   = '0;
    jmp_id    = '0;
    name_size = '0;
    capturing = 1'b0;
    halted    = 1'b0;
  endtask

  function automatic out_t parse_byte(in_t item);
    out_t       r;
    logic [7:0] b;
    logic [7:0] keep;
    logic [31:0] idx;
    bit         done;
    r = '0;
    b = item.rx_byte;
    done = 1'b1;
    if (!halted) begin
      case (phase)
        PH_CMD: begin
          case (b)
            OP_LOAD: begin
              phase = PH_LOAD_HDR;
              hdr_cnt = '0;
              base_addr = '0;
              pay_size = '0;
              pay_off = '0;
              r.record_byte = capturing;
              done = 1'b0;
            end
            OP_JUMP: begin
              phase = PH_JUMP_HDR;
              hdr_cnt = '0;
              jmp_id = '0;
              base_addr = '0;
              r.record_byte = capturing;
              done = 1'b0;
            end
            OP_RESET: begin
              r.event_res = EV_RESET;
              capturing = 1'b0;
            end
            OP_REBOOT: begin
              r.event_res = EV_REBOOT;
              halted = 1'b1;
            end
            OP_SET_NAME: begin
              phase = PH_NAME_LEN;
              done = 1'b0;
            end
            OP_AR_BEGIN: begin
              r.event_res = EV_AR_BEGIN;
              capturing = 1'b1;
            end
            OP_AR_END: begin
              r.event_res = EV_AR_END;
              capturing = 1'b0;
            end
            OP_AR_CLEAR: begin
              r.event_res = EV_AR_CLEAR;
              capturing = 1'b0;
            end
            default: begin
              r.event_res = EV_STOP;
              halted = 1'b1;
            end
          endcase
        end
        PH_LOAD_HDR: begin
          r.record_byte = capturing;
          if (hdr_cnt < 3'd4) base_addr[8*hdr_cnt[1:0] +: 8] = b;
          else pay_size[8*hdr_cnt[1:0] +: 8] = b;
          if (hdr_cnt == 3'd7) begin
            hdr_cnt = '0;
            pay_off = '0;
            if (pay_size == '0) begin
              phase = PH_CMD;
            end else begin
              phase = PH_LOAD_DATA;
              done = 1'b0;
            end
          end else begin
            hdr_cnt++;
            done = 1'b0;
          end
        end
        PH_LOAD_DATA: begin
          r.record_byte = capturing;
          r.event_res = EV_MEM_WRITE;
          r.target_address = (base_addr + pay_off) & ADDR_MASK;
          r.data_value = b;
          pay_off++;
          if (pay_off >= pay_size) phase = PH_CMD;
          else done = 1'b0;
        end
        PH_JUMP_HDR: begin
          r.record_byte = capturing;
          if (hdr_cnt < 3'd4) jmp_id[8*hdr_cnt[1:0] +: 8] = b;
          else base_addr[8*hdr_cnt[1:0] +: 8] = b;
          if (hdr_cnt == 3'd7) begin
            hdr_cnt = '0;
            r.event_res = EV_SET_MAIN;
            r.target_address = base_addr & ADDR_MASK;
            r.program_id = jmp_id;
            phase = PH_CMD;
          end else begin
            hdr_cnt++;
            done = 1'b0;
          end
        end
        PH_NAME_LEN: begin
          name_size = b;
          pay_off = '0;
          if (b == 8'd0) begin
            r.event_res = EV_NAME_DONE;
            phase = PH_CMD;
          end else begin
            phase = PH_NAME_DATA;
            done = 1'b0;
          end
        end
        PH_NAME_DATA: begin
          idx = pay_off;
          keep = (name_size > NAME_KEEP) ? NAME_KEEP : name_size;
          pay_off++;
          if (pay_off >= {24'd0, name_size}) begin
            r.event_res = EV_NAME_DONE;
            r.name_position = keep[5:0];
            r.data_value = (idx < {24'd0, keep}) ? b : 8'h00;
            phase = PH_CMD;
            if (name_size > NAME_KEEP) n_long_names++;
          end else begin
            if (idx < {24'd0, keep}) begin
              r.event_res = EV_NAME_CHAR;
              r.name_position = idx[5:0];
              r.data_value = b;
            end
            done = 1'b0;
          end
        end
        default: phase = PH_CMD;
      endcase
    end
    if (item.buffer_end) begin
      if (!done) begin
        r.event_res = EV_TRUNC;
        r.target_address = '0;
        r.data_value = '0;
        r.program_id = '0;
        r.name_position = '0;
      end
      phase = PH_CMD;
      hdr_cnt = '0;
      halted = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h", $realtime, n_checked, what,
             got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (event_q.size() == 0) begin
      report_mismatch("unexpected result, event_res", 32'(got.event_res), '0);
      return;
    end
    want = event_q.pop_front();
    n_checked++;
    if (got.event_res !== want.event_res)
      report_mismatch("event_res", 32'(got.event_res), 32'(want.event_res));
    if (got.target_address !== want.target_address)
      report_mismatch("target_address", got.target_address, want.target_address);
    if (got.data_value !== want.data_value)
      report_mismatch("data_value", 32'(got.data_value), 32'(want.data_value));
    if (got.program_id !== want.program_id)
      report_mismatch("program_id", got.program_id, want.program_id);
    if (got.name_position !== want.name_position)
      report_mismatch("name_position", 32'(got.name_position), 32'(want.name_position));
    if (got.record_byte !== want.record_byte)
      report_mismatch("record_byte", 32'(got.record_byte), 32'(want.record_byte));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending", cycle_count,
               event_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_t  item;
    out_t r;
    item.rx_byte = b;
    item.buffer_end = last;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    if (!halted) n_parsed++;
    r = parse_byte(item);
    ev_seen[r.event_res]++;
    event_q.push_back(r);
    n_bytes++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic flush_buffer();
    foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
    n_buffers++;
    buf_q.delete();
  endtask

  task automatic add_word_le(input logic [31:0] w);
    for (int k = 0; k < 4; k++) buf_q.push_back(w[8*k +: 8]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (event_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_single_commands();
    buf_q = '{OP_AR_BEGIN, OP_AR_END, OP_AR_CLEAR, OP_RESET, OP_AR_BEGIN};
    flush_buffer();
  endtask

  // capture stays on from the previous buffer
  task automatic test_load_and_jump();
    buf_q.push_back(OP_LOAD);
    add_word_le(32'hFFFF_FFFF);
    add_word_le(32'd2);
    buf_q.push_back(8'h00);
    buf_q.push_back(8'hFF);
    buf_q.push_back(OP_JUMP);
    add_word_le(32'h8000_0000);
    add_word_le(32'h0000_0000);
    buf_q.push_back(OP_LOAD);
    add_word_le(32'h1234_5678);
    add_word_le(32'd0);
    flush_buffer();
  endtask

  task automatic test_names();
    buf_q = '{OP_RESET, OP_SET_NAME, 8'd0, OP_SET_NAME, 8'd1, 8'h41};
    flush_buffer();
  endtask

  task automatic test_name_truncation();
    buf_q = '{OP_SET_NAME, 8'd64};
    for (int i = 0; i < 64; i++) buf_q.push_back(8'(8'h20 + i));
    flush_buffer();
  endtask

  task automatic test_stop_and_cutoff();
    buf_q = '{OP_REBOOT, OP_LOAD, OP_AR_BEGIN};
    flush_buffer();
    buf_q = '{OP_STOP, 8'hFF};
    flush_buffer();
    buf_q = '{8'hFF};
    flush_buffer();
    buf_q = '{OP_LOAD};
    flush_buffer();
    buf_q = '{OP_AR_BEGIN, OP_JUMP, 8'h10};
    flush_buffer();
    buf_q.push_back(OP_LOAD);
    add_word_le(32'h0000_1000);
    add_word_le(32'd3);
    buf_q.push_back(8'hA5);
    buf_q.push_back(8'h5A);
    flush_buffer();
    buf_q = '{OP_SET_NAME, 8'd3, 8'h61};
    flush_buffer();
    buf_q = '{OP_SET_NAME};
    flush_buffer();
  endtask

  task automatic add_random_frame();
    int          pick;
    int          n;
    logic [7:0]  op;
    logic [31:0] a;
    pick = $urandom_range(0, 99);
    a = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom();
    if (pick < 30) begin
      buf_q.push_back(OP_LOAD);
      add_word_le(a);
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      add_word_le(n);
      repeat (n) buf_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 45) begin
      buf_q.push_back(OP_JUMP);
      add_word_le($urandom());
      add_word_le(a);
    end else if (pick < 57) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 6);
      buf_q.push_back(OP_SET_NAME);
      buf_q.push_back(8'(n));
      repeat (n) buf_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      case ($urandom_range(0, 4))
        0: buf_q.push_back(OP_RESET);
        1: buf_q.push_back(OP_AR_END);
        2: buf_q.push_back(OP_AR_CLEAR);
        default: buf_q.push_back(OP_AR_BEGIN);
      endcase
    end else if (pick < 89) begin
      buf_q.push_back(OP_REBOOT);
    end else begin
      op = 8'($urandom_range(0, 255));
      if (pick < 94 && (op == OP_LOAD || op == OP_JUMP || op == OP_RESET || op == OP_REBOOT ||
          op == OP_SET_NAME || op == OP_AR_BEGIN || op == OP_AR_END || op == OP_AR_CLEAR))
        op = OP_STOP;
      buf_q.push_back(op);
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
    int target;
    int cut;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = n_parsed + n;
    while (n_parsed < target) begin
      repeat ($urandom_range(1, 4)) add_random_frame();
      if ($urandom_range(0, 99) < 15) begin
        cut = $urandom_range(1, buf_q.size());
        while (buf_q.size() > cut) void'(buf_q.pop_back());
      end
      flush_buffer();
    end
    wait_idle();
  endtask

  initial begin
    int kinds;
    clear_parser_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_single_commands();
    test_load_and_jump();
    test_names();
    test_name_truncation();
    test_stop_and_cutoff();
    wait_idle();
    test_random_traffic(0, 0, 70);
    test_random_traffic(57, 0, 70);
    test_random_traffic(0, 57, 70);
    test_random_traffic(27, 27, 70);
    kinds = 0;
    foreach (ev_seen[i]) if (ev_seen[i] != 0) kinds++;
    $display("Sent %0d bytes in %0d buffers, checked %0d results in %0d cycles", n_bytes,
             n_buffers, n_checked, cycle_count);
    $display("Saw %0d event kinds, %0d cut-off frames, %0d over-long names", kinds,
             ev_seen[EV_TRUNC], n_long_names);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
